// ----- hw/rtl/env_sensor_compensation_unit_assert.svh -----
// Assertion macros for the sensor compensation unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ESCU_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("escu check failed");
`define ESCU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escu check failed");
`define ESCU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escu check failed");
`else
`define ESCU_ASSERT(lbl, clk, rst, expr)
`define ESCU_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ESCU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/escu_pkg.sv -----
// Shared types and constants of the sensor compensation unit.
// Used by escu_div, env_sensor_compensation_unit and the testbench files; no dependencies.
package escu_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CALIB      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CALIB_A   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CALIB_B   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_HUM_CALIB = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_CALIB       = 3'd4;

   localparam int unsigned DIV_BITS = 64;

   localparam logic [33:0] P_FINE_OFFSET = 34'd128000;
   localparam logic [20:0] P_RAW_OFFSET  = 21'd1048576;
   localparam logic [63:0] P_SCALE       = 64'd3125;
   localparam logic [31:0] H_FINE_OFFSET = 32'd76800;
   localparam logic [31:0] H_B_OFFSET    = 32'd2097152;
   localparam logic [31:0] H_ACC_MAX     = 32'd419430400;
   localparam logic [16:0] HUM_OUT_MAX   = 17'd102400;
   localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
   localparam logic signed [31:0] TEMP_MIN = -32'sd32768;

   typedef struct packed {
      logic [15:0] centi;
      logic [16:0] hum;
      logic        fault;
   } escu_side_type;

   typedef struct packed {
      logic [63:0]   rem;
      logic [63:0]   rq;
      logic [63:0]   den;
      logic          neg;
      escu_side_type side;
   } escu_div_stage_type;

endpackage

// ----- hw/rtl/env_sensor_compensation_unit.sv -----
// Top level of the sensor compensation unit: calibration registers, pipeline, output skid.
// Depends on escu_pkg, escu_div and env_sensor_compensation_unit_assert.svh.
//
// Takes one raw temperature/pressure/humidity word per cycle while req_stall is low and
// returns one compensated word per cycle while rsp_stall is low, in order. Most of the
// pipeline is the pressure division, a 66-register pipeline (an input stage, 64 stages
// retiring one quotient bit each, and an output stage); the front end is 13 stages, the
// pressure back end 5 more and the output register one. An output register plus a one-word
// skid stage decouple rsp_stall from the input: req_stall rises only once both are full.
// Calibration registers reset to zero and must only be written while the unit is empty.
`include "env_sensor_compensation_unit_assert.svh"
module env_sensor_compensation_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [escu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [19:0]                        req_raw_temp,
   input  logic [19:0]                        req_raw_press,
   input  logic [15:0]                        req_raw_hum,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [15:0]                 rsp_temp_centi,
   output logic [31:0]                        rsp_press_q24_8,
   output logic [16:0]                        rsp_hum_q22_10,
   output logic                               rsp_press_fault
);

   // calibration
   logic [47:0] temp_calib_ff;
   logic [63:0] press_calib_a_ff;
   logic [63:0] press_calib_b_ff;
   logic [47:0] press_hum_calib_ff;
   logic [31:0] hum_calib_ff;

   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]  h1, h3, h6;
   logic [11:0] h4, h5;

   assign t1 = temp_calib_ff[15:0];
   assign t2 = temp_calib_ff[31:16];
   assign t3 = temp_calib_ff[47:32];
   assign p1 = press_calib_a_ff[15:0];
   assign p2 = press_calib_a_ff[31:16];
   assign p3 = press_calib_a_ff[47:32];
   assign p4 = press_calib_a_ff[63:48];
   assign p5 = press_calib_b_ff[15:0];
   assign p6 = press_calib_b_ff[31:16];
   assign p7 = press_calib_b_ff[47:32];
   assign p8 = press_calib_b_ff[63:48];
   assign p9 = press_hum_calib_ff[15:0];
   assign h1 = press_hum_calib_ff[23:16];
   assign h2 = press_hum_calib_ff[39:24];
   assign h3 = press_hum_calib_ff[47:40];
   assign h4 = hum_calib_ff[11:0];
   assign h5 = hum_calib_ff[23:12];
   assign h6 = hum_calib_ff[31:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff      <= '0;
         press_calib_a_ff   <= '0;
         press_calib_b_ff   <= '0;
         press_hum_calib_ff <= '0;
         hum_calib_ff       <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            escu_pkg::CSR_TEMP_CALIB:      temp_calib_ff      <= csr_wdata[47:0];
            escu_pkg::CSR_PRESS_CALIB_A:   press_calib_a_ff   <= csr_wdata;
            escu_pkg::CSR_PRESS_CALIB_B:   press_calib_b_ff   <= csr_wdata;
            escu_pkg::CSR_PRESS_HUM_CALIB: press_hum_calib_ff <= csr_wdata[47:0];
            escu_pkg::CSR_HUM_CALIB:       hum_calib_ff       <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   // front pipeline registers
   logic [12:0] fv_ff, fv_in;

   logic [19:0] s0_temp_ff, s0_press_ff, s0_press_in, s0_temp_in;
   logic [15:0] s0_hum_ff, s0_hum_in;

   logic [31:0] s1_lin_ff, s1_lin_in, s1_dd_ff, s1_dd_in;
   logic [19:0] s1_press_ff, s1_press_in;
   logic [15:0] s1_hum_ff, s1_hum_in;

   logic [31:0] s2_lin_ff, s2_lin_in, s2_quad_ff, s2_quad_in;
   logic [19:0] s2_press_ff, s2_press_in;
   logic [15:0] s2_hum_ff, s2_hum_in;

   logic [31:0] s3_fine_ff, s3_fine_in;
   logic [19:0] s3_press_ff, s3_press_in;
   logic [15:0] s3_hum_ff, s3_hum_in;

   logic [15:0] s4_centi_ff, s4_centi_in;
   logic [33:0] s4_x_ff, s4_x_in;
   logic [31:0] s4_hv_ff, s4_hv_in;
   logic [19:0] s4_press_ff, s4_press_in;
   logic [15:0] s4_hum_ff, s4_hum_in;

   logic [63:0] s5_xx_ff, s5_xx_in, s5_xp5_ff, s5_xp5_in, s5_xp2_ff, s5_xp2_in;
   logic [31:0] s5_m5_ff, s5_m5_in, s5_mv6_ff, s5_mv6_in, s5_mv3_ff, s5_mv3_in;
   logic [20:0] s5_pr_ff, s5_pr_in;
   logic [15:0] s5_hum_ff, s5_hum_in, s5_centi_ff, s5_centi_in;

   logic [63:0] s6_ya_ff, s6_ya_in, s6_tp3_ff, s6_tp3_in, s6_yb_ff, s6_yb_in;
   logic [63:0] s6_xs2_ff, s6_xs2_in;
   logic [31:0] s6_ha_ff, s6_ha_in, s6_b1_ff, s6_b1_in, s6_b2_ff, s6_b2_in;
   logic [20:0] s6_pr_ff, s6_pr_in;
   logic [15:0] s6_centi_ff, s6_centi_in;

   logic [63:0] s7_y_ff, s7_y_in, s7_v_ff, s7_v_in;
   logic [31:0] s7_ha_ff, s7_ha_in, s7_b_ff, s7_b_in;
   logic [20:0] s7_pr_ff, s7_pr_in;
   logic [15:0] s7_centi_ff, s7_centi_in;

   logic [63:0] s8_pp1_ff, s8_pp1_in, s8_n0_ff, s8_n0_in;
   logic [31:0] s8_ha_ff, s8_ha_in, s8_b4_ff, s8_b4_in;
   logic [15:0] s8_centi_ff, s8_centi_in;

   logic [63:0] s9_xd_ff, s9_xd_in, s9_num_ff, s9_num_in;
   logic [31:0] s9_hv2_ff, s9_hv2_in;
   logic [15:0] s9_centi_ff, s9_centi_in;

   logic [63:0] s10_xd_ff, s10_xd_in, s10_num_ff, s10_num_in;
   logic        s10_fault_ff, s10_fault_in;
   logic [31:0] s10_ss_ff, s10_ss_in, s10_hv2_ff, s10_hv2_in;
   logic [15:0] s10_centi_ff, s10_centi_in;

   logic [63:0] s11_xd_ff, s11_xd_in, s11_num_ff, s11_num_in;
   logic        s11_fault_ff, s11_fault_in;
   logic [31:0] s11_m1_ff, s11_m1_in, s11_hv2_ff, s11_hv2_in;
   logic [15:0] s11_centi_ff, s11_centi_in;

   logic [63:0]             s12_xd_ff, s12_xd_in, s12_num_ff, s12_num_in;
   escu_pkg::escu_side_type s12_side_ff, s12_side_in;

   // front temporaries
   logic [31:0] rt32, a_t, d_t, dd_sra, t5, tc, lin_sra, quad_sra;
   logic [31:0] h_acc, mv6_sra, mv3_sra, b_sra, b3, b4p, b5, hv_sra, ss_sra, m1_sra;
   logic [31:0] hv3, hclamp;
   logic [63:0] tp3_sra, pp1_sra;

   always_comb begin
      fv_in = {fv_ff[11:0], req_valid && !req_stall};

      s0_temp_in  = req_raw_temp;
      s0_press_in = req_raw_press;
      s0_hum_in   = req_raw_hum;

      // temperature
      rt32        = {12'd0, s0_temp_ff};
      a_t         = (rt32 >> 3) - {15'd0, t1, 1'b0};
      d_t         = (rt32 >> 4) - {16'd0, t1};
      s1_lin_in   = $signed(a_t) * $signed(t2);
      s1_dd_in    = d_t * d_t;
      s1_press_in = s0_press_ff;
      s1_hum_in   = s0_hum_ff;

      lin_sra     = $signed(s1_lin_ff) >>> 11;
      dd_sra      = $signed(s1_dd_ff) >>> 12;
      s2_lin_in   = lin_sra;
      s2_quad_in  = $signed(dd_sra) * $signed(t3);
      s2_press_in = s1_press_ff;
      s2_hum_in   = s1_hum_ff;

      quad_sra    = $signed(s2_quad_ff) >>> 14;
      s3_fine_in  = s2_lin_ff + quad_sra;
      s3_press_in = s2_press_ff;
      s3_hum_in   = s2_hum_ff;

      t5 = s3_fine_ff * 32'd5 + 32'd128;
      tc = $signed(t5) >>> 8;
      if ($signed(tc) > escu_pkg::TEMP_MAX) begin
         s4_centi_in = 16'h7fff;
      end else if ($signed(tc) < escu_pkg::TEMP_MIN) begin
         s4_centi_in = 16'h8000;
      end else begin
         s4_centi_in = tc[15:0];
      end
      s4_x_in     = {{2{s3_fine_ff[31]}}, s3_fine_ff} - escu_pkg::P_FINE_OFFSET;
      s4_hv_in    = s3_fine_ff - escu_pkg::H_FINE_OFFSET;
      s4_press_in = s3_press_ff;
      s4_hum_in   = s3_hum_ff;

      // pressure coefficients and humidity products
      s5_xx_in    = $signed(s4_x_ff) * $signed(s4_x_ff);
      s5_xp5_in   = $signed(s4_x_ff) * $signed(p5);
      s5_xp2_in   = $signed(s4_x_ff) * $signed(p2);
      s5_m5_in    = $signed(h5) * $signed(s4_hv_ff);
      s5_mv6_in   = $signed(s4_hv_ff) * $signed(h6);
      s5_mv3_in   = $signed(s4_hv_ff) * $signed({1'b0, h3});
      s5_pr_in    = escu_pkg::P_RAW_OFFSET - {1'b0, s4_press_ff};
      s5_hum_in   = s4_hum_ff;
      s5_centi_in = s4_centi_ff;

      s6_ya_in  = $signed(s5_xx_ff) * $signed(p6);
      s6_tp3_in = $signed(s5_xx_ff) * $signed(p3);
      s6_yb_in  = (s5_xp5_ff << 17) + ({{48{p4[15]}}, p4} << 35);
      s6_xs2_in = s5_xp2_ff << 12;
      h_acc     = ({16'd0, s5_hum_ff} << 14) - ({{20{h4[11]}}, h4} << 20)
                  - s5_m5_ff + 32'd16384;
      s6_ha_in  = $signed(h_acc) >>> 15;
      mv6_sra   = $signed(s5_mv6_ff) >>> 10;
      mv3_sra   = $signed(s5_mv3_ff) >>> 11;
      s6_b1_in  = mv6_sra;
      s6_b2_in  = mv3_sra + 32'd32768;
      s6_pr_in    = s5_pr_ff;
      s6_centi_in = s5_centi_ff;

      tp3_sra     = $signed(s6_tp3_ff) >>> 8;
      s7_y_in     = s6_ya_ff + s6_yb_ff;
      s7_v_in     = tp3_sra + s6_xs2_ff + (64'd1 << 47);
      s7_ha_in    = s6_ha_ff;
      s7_b_in     = $signed(s6_b1_ff) * $signed(s6_b2_ff);
      s7_pr_in    = s6_pr_ff;
      s7_centi_in = s6_centi_ff;

      s8_pp1_in   = $signed(s7_v_ff) * $signed({1'b0, p1});
      s8_n0_in    = ({43'd0, s7_pr_ff} << 31) - s7_y_ff;
      b_sra       = $signed(s7_b_ff) >>> 10;
      b3          = b_sra + escu_pkg::H_B_OFFSET;
      s8_b4_in    = $signed(b3) * $signed(h2);
      s8_ha_in    = s7_ha_ff;
      s8_centi_in = s7_centi_ff;

      pp1_sra     = $signed(s8_pp1_ff) >>> 33;
      s9_xd_in    = pp1_sra;
      s9_num_in   = s8_n0_ff * escu_pkg::P_SCALE;
      b4p         = s8_b4_ff + 32'd8192;
      b5          = $signed(b4p) >>> 14;
      s9_hv2_in   = $signed(s8_ha_ff) * $signed(b5);
      s9_centi_in = s8_centi_ff;

      s10_xd_in    = s9_xd_ff;
      s10_num_in   = s9_num_ff;
      s10_fault_in = (s9_xd_ff == 64'd0);
      hv_sra       = $signed(s9_hv2_ff) >>> 15;
      s10_ss_in    = hv_sra * hv_sra;
      s10_hv2_in   = s9_hv2_ff;
      s10_centi_in = s9_centi_ff;

      s11_xd_in    = s10_xd_ff;
      s11_num_in   = s10_num_ff;
      s11_fault_in = s10_fault_ff;
      ss_sra       = $signed(s10_ss_ff) >>> 7;
      s11_m1_in    = $signed(ss_sra) * $signed({1'b0, h1});
      s11_hv2_in   = s10_hv2_ff;
      s11_centi_in = s10_centi_ff;

      m1_sra = $signed(s11_m1_ff) >>> 4;
      hv3    = s11_hv2_ff - m1_sra;
      priority if (hv3[31]) begin
         hclamp = 32'd0;
      end else if (hv3 > escu_pkg::H_ACC_MAX) begin
         hclamp = escu_pkg::H_ACC_MAX;
      end else begin
         hclamp = hv3;
      end
      s12_xd_in         = s11_xd_ff;
      s12_num_in        = s11_num_ff;
      s12_side_in.centi = s11_centi_ff;
      s12_side_in.hum   = hclamp[28:12];
      s12_side_in.fault = s11_fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_temp_ff  <= s0_temp_in;   s0_press_ff <= s0_press_in; s0_hum_ff <= s0_hum_in;
         s1_lin_ff   <= s1_lin_in;    s1_dd_ff    <= s1_dd_in;
         s1_press_ff <= s1_press_in;  s1_hum_ff   <= s1_hum_in;
         s2_lin_ff   <= s2_lin_in;    s2_quad_ff  <= s2_quad_in;
         s2_press_ff <= s2_press_in;  s2_hum_ff   <= s2_hum_in;
         s3_fine_ff  <= s3_fine_in;   s3_press_ff <= s3_press_in; s3_hum_ff <= s3_hum_in;
         s4_centi_ff <= s4_centi_in;  s4_x_ff     <= s4_x_in;     s4_hv_ff  <= s4_hv_in;
         s4_press_ff <= s4_press_in;  s4_hum_ff   <= s4_hum_in;
         s5_xx_ff    <= s5_xx_in;     s5_xp5_ff   <= s5_xp5_in;   s5_xp2_ff <= s5_xp2_in;
         s5_m5_ff    <= s5_m5_in;     s5_mv6_ff   <= s5_mv6_in;   s5_mv3_ff <= s5_mv3_in;
         s5_pr_ff    <= s5_pr_in;     s5_hum_ff   <= s5_hum_in;   s5_centi_ff <= s5_centi_in;
         s6_ya_ff    <= s6_ya_in;     s6_tp3_ff   <= s6_tp3_in;   s6_yb_ff  <= s6_yb_in;
         s6_xs2_ff   <= s6_xs2_in;    s6_ha_ff    <= s6_ha_in;
         s6_b1_ff    <= s6_b1_in;     s6_b2_ff    <= s6_b2_in;
         s6_pr_ff    <= s6_pr_in;     s6_centi_ff <= s6_centi_in;
         s7_y_ff     <= s7_y_in;      s7_v_ff     <= s7_v_in;
         s7_ha_ff    <= s7_ha_in;     s7_b_ff     <= s7_b_in;
         s7_pr_ff    <= s7_pr_in;     s7_centi_ff <= s7_centi_in;
         s8_pp1_ff   <= s8_pp1_in;    s8_n0_ff    <= s8_n0_in;
         s8_ha_ff    <= s8_ha_in;     s8_b4_ff    <= s8_b4_in;    s8_centi_ff <= s8_centi_in;
         s9_xd_ff    <= s9_xd_in;     s9_num_ff   <= s9_num_in;
         s9_hv2_ff   <= s9_hv2_in;    s9_centi_ff <= s9_centi_in;
         s10_xd_ff   <= s10_xd_in;    s10_num_ff  <= s10_num_in;  s10_fault_ff <= s10_fault_in;
         s10_ss_ff   <= s10_ss_in;    s10_hv2_ff  <= s10_hv2_in;  s10_centi_ff <= s10_centi_in;
         s11_xd_ff   <= s11_xd_in;    s11_num_ff  <= s11_num_in;  s11_fault_ff <= s11_fault_in;
         s11_m1_ff   <= s11_m1_in;    s11_hv2_ff  <= s11_hv2_in;  s11_centi_ff <= s11_centi_in;
         s12_xd_ff   <= s12_xd_in;    s12_num_ff  <= s12_num_in;  s12_side_ff <= s12_side_in;
      end
   end

   // division
   logic                    dq_valid;
   logic [63:0]             dq;
   escu_pkg::escu_side_type dside;

   escu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fv_ff[12]),
      .in_num    (s12_num_ff),
      .in_den    (s12_xd_ff),
      .in_side   (s12_side_ff),
      .out_valid (dq_valid),
      .out_quot  (dq),
      .out_side  (dside)
   );

   // pressure back end
   logic [4:0] qv_ff, qv_in;

   logic [63:0] q1_q_ff, q1_q_in, q1_ll_ff, q1_ll_in, q1_p8q_ff, q1_p8q_in;
   logic [31:0] q1_lh_ff, q1_lh_in;
   escu_pkg::escu_side_type q1_side_ff, q2_side_ff, q3_side_ff, q4_side_ff, q5_side_ff;

   logic [63:0] q2_q_ff, q2_q_in, q2_ss_ff, q2_ss_in, q2_e2_ff, q2_e2_in;
   logic [63:0] q3_q_ff, q3_p9ss_ff, q3_p9ss_in, q3_e2_ff;
   logic [63:0] q4_sum_ff, q4_sum_in;
   logic [31:0] q5_press_ff, q5_press_in;

   logic [63:0] s_q, p8q_sra, p9ss_sra, sum_sra, prp;

   always_comb begin
      qv_in = {qv_ff[3:0], dq_valid};

      s_q       = $signed(dq) >>> 13;
      q1_q_in   = dq;
      q1_ll_in  = {32'd0, s_q[31:0]} * {32'd0, s_q[31:0]};
      q1_lh_in  = s_q[31:0] * s_q[63:32];
      q1_p8q_in = $signed(dq) * $signed(p8);

      p8q_sra  = $signed(q1_p8q_ff) >>> 19;
      q2_q_in  = q1_q_ff;
      q2_ss_in = q1_ll_ff + ({q1_lh_ff, 32'd0} << 1);
      q2_e2_in = p8q_sra;

      q3_p9ss_in = $signed(q2_ss_ff) * $signed(p9);

      p9ss_sra  = $signed(q3_p9ss_ff) >>> 25;
      q4_sum_in = q3_q_ff + p9ss_sra + q3_e2_ff;

      sum_sra = $signed(q4_sum_ff) >>> 8;
      prp     = sum_sra + ({{48{p7[15]}}, p7} << 4);
      priority if (q4_side_ff.fault || prp[63]) begin
         q5_press_in = 32'd0;
      end else if (prp[63:32] != 32'd0) begin
         q5_press_in = 32'hffff_ffff;
      end else begin
         q5_press_in = prp[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= '0;
      end else if (en) begin
         qv_ff <= qv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_q_ff    <= q1_q_in;   q1_ll_ff   <= q1_ll_in;   q1_lh_ff <= q1_lh_in;
         q1_p8q_ff  <= q1_p8q_in; q1_side_ff <= dside;
         q2_q_ff    <= q2_q_in;   q2_ss_ff   <= q2_ss_in;   q2_e2_ff <= q2_e2_in;
         q2_side_ff <= q1_side_ff;
         q3_q_ff    <= q2_q_ff;   q3_p9ss_ff <= q3_p9ss_in; q3_e2_ff <= q2_e2_ff;
         q3_side_ff <= q2_side_ff;
         q4_sum_ff  <= q4_sum_in; q4_side_ff <= q3_side_ff;
         q5_press_ff <= q5_press_in; q5_side_ff <= q4_side_ff;
      end
   end

   // output register and skid
   logic [15:0] rsp_temp_centi_ff, rsp_temp_centi_in, skid_centi_ff, skid_centi_in;
   logic [31:0] rsp_press_q24_8_ff, rsp_press_q24_8_in, skid_press_ff, skid_press_in;
   logic [16:0] rsp_hum_q22_10_ff, rsp_hum_q22_10_in, skid_hum_ff, skid_hum_in;
   logic        rsp_press_fault_ff, rsp_press_fault_in, skid_fault_ff, skid_fault_in;

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !take;
      skid_valid_in      = skid_valid_ff;
      rsp_temp_centi_in  = rsp_temp_centi_ff;
      rsp_press_q24_8_in = rsp_press_q24_8_ff;
      rsp_hum_q22_10_in  = rsp_hum_q22_10_ff;
      rsp_press_fault_in = rsp_press_fault_ff;
      skid_centi_in      = q5_side_ff.centi;
      skid_press_in      = q5_press_ff;
      skid_hum_in        = q5_side_ff.hum;
      skid_fault_in      = q5_side_ff.fault;
      priority if (en && (!rsp_valid_ff || take)) begin
         rsp_valid_in       = qv_ff[4];
         rsp_temp_centi_in  = q5_side_ff.centi;
         rsp_press_q24_8_in = q5_press_ff;
         rsp_hum_q22_10_in  = q5_side_ff.hum;
         rsp_press_fault_in = q5_side_ff.fault;
      end else if (en) begin
         skid_valid_in = qv_ff[4];
      end else if (take) begin
         rsp_valid_in       = 1'b1;
         skid_valid_in      = 1'b0;
         rsp_temp_centi_in  = skid_centi_ff;
         rsp_press_q24_8_in = skid_press_ff;
         rsp_hum_q22_10_in  = skid_hum_ff;
         rsp_press_fault_in = skid_fault_ff;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_centi_ff  <= rsp_temp_centi_in;
      rsp_press_q24_8_ff <= rsp_press_q24_8_in;
      rsp_hum_q22_10_ff  <= rsp_hum_q22_10_in;
      rsp_press_fault_ff <= rsp_press_fault_in;
      if (en && rsp_valid_ff && !take) begin
         skid_centi_ff <= skid_centi_in;
         skid_press_ff <= skid_press_in;
         skid_hum_ff   <= skid_hum_in;
         skid_fault_ff <= skid_fault_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temp_centi  = rsp_temp_centi_ff;
   assign rsp_press_q24_8 = rsp_press_q24_8_ff;
   assign rsp_hum_q22_10  = rsp_hum_q22_10_ff;
   assign rsp_press_fault = rsp_press_fault_ff;

   `ESCU_ASSERT(a_skid_needs_out, clock, reset, !skid_valid_ff || rsp_valid_ff)
   `ESCU_ASSERT_IMPL(a_fault_zero, clock, reset, rsp_valid_ff && rsp_press_fault_ff, rsp_press_q24_8_ff == 32'd0)
   `ESCU_ASSERT_IMPL(a_hum_range, clock, reset, rsp_valid_ff, rsp_hum_q22_10_ff <= escu_pkg::HUM_OUT_MAX)
   `ESCU_ASSERT_NEXT(a_skid_hold, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff)

endmodule

// ----- hw/rtl/escu_div.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on escu_pkg for the stage and side-data types.
module escu_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [63:0]             in_num,
   input  logic [63:0]             in_den,
   input  escu_pkg::escu_side_type in_side,
   output logic                    out_valid,
   output logic [63:0]             out_quot,
   output escu_pkg::escu_side_type out_side
);

   localparam int unsigned N = escu_pkg::DIV_BITS;

   escu_pkg::escu_div_stage_type stg_ff [N+1];
   escu_pkg::escu_div_stage_type stg_in [N+1];
   logic [N:0]              vld_ff;
   logic                    out_valid_ff;
   logic [63:0]             out_quot_ff;
   logic [63:0]             out_quot_in;
   escu_pkg::escu_side_type out_side_ff;

   always_comb begin
      logic [64:0] trial;
      logic [64:0] diff;
      stg_in[0].neg  = in_num[63] ^ in_den[63];
      stg_in[0].rq   = in_num[63] ? (64'd0 - in_num) : in_num;
      stg_in[0].den  = in_den[63] ? (64'd0 - in_den) : in_den;
      stg_in[0].rem  = '0;
      stg_in[0].side = in_side;
      for (int k = 1; k <= N; k++) begin
         trial     = {stg_ff[k-1].rem, stg_ff[k-1].rq[63]};
         diff      = trial - {1'b0, stg_ff[k-1].den};
         stg_in[k] = stg_ff[k-1];
         if (!diff[64]) begin
            stg_in[k].rem = diff[63:0];
            stg_in[k].rq  = {stg_ff[k-1].rq[62:0], 1'b1};
         end else begin
            stg_in[k].rem = trial[63:0];
            stg_in[k].rq  = {stg_ff[k-1].rq[62:0], 1'b0};
         end
      end
      out_quot_in = stg_ff[N].neg ? (64'd0 - stg_ff[N].rq) : stg_ff[N].rq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[N-1:0], in_valid};
         out_valid_ff <= vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff      <= stg_in;
         out_quot_ff <= out_quot_in;
         out_side_ff <= stg_ff[N].side;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_quot_ff;
   assign out_side  = out_side_ff;

endmodule

// ----- tb/sv/env_sensor_compensation_unit_checker.sv -----
// Checker for the sensor compensation unit: watches the config port and both channels,
// predicts each result word and compares it with what the unit returns.
// Depends on escu_pkg for the register indexes.
`timescale 1ns / 1ps
module env_sensor_compensation_unit_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [escu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [19:0]                      req_raw_temp,
   input  logic [19:0]                      req_raw_press,
   input  logic [15:0]                      req_raw_hum,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [15:0]               rsp_temp_centi,
   input  logic [31:0]                      rsp_press_q24_8,
   input  logic [16:0]                      rsp_hum_q22_10,
   input  logic                             rsp_press_fault,
   output int                               mismatches,
   output int                               pending
);

   typedef struct packed {
      logic [15:0] temp_centi;
      logic [31:0] press;
      logic [16:0] hum;
      logic        fault;
   } comp_word_type;

   logic [47:0]   temp_cal;
   logic [63:0]   press_cal_a;
   logic [63:0]   press_cal_b;
   logic [47:0]   press_hum_cal;
   logic [31:0]   hum_cal;
   comp_word_type expected_words[$];

   function automatic logic [31:0] asr32(logic [31:0] x, int n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, int n);
      logic signed [63:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
      logic [63:0] mn, md, q;
      mn = n[63] ? 64'd0 - n : n;
      md = d[63] ? 64'd0 - d : d;
      q = mn / md;
      return (n[63] != d[63]) ? 64'd0 - q : q;
   endfunction

   function automatic comp_word_type compensate(logic [19:0] rt_in, logic [19:0] rp_in,
                                                logic [15:0] rh_in);
      comp_word_type w;
      logic [31:0] rt, t1, t2, t3, a, lin, d, m, quad, fine, tc;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x, y, pr, e1, e2, q;
      logic [31:0] rh, h1, h2, h3, h4, h5, h6, v, ha, hb, hc, s;
      rt = {12'd0, rt_in};
      t1 = {16'd0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      a = (rt >> 3) - (t1 << 1);
      m = a * t2;
      lin = asr32(m, 11);
      d = (rt >> 4) - t1;
      m = d * d;
      m = asr32(m, 12);
      m = m * t3;
      quad = asr32(m, 14);
      fine = lin + quad;
      m = fine * 32'd5 + 32'd128;
      tc = asr32(m, 8);
      if ($signed(tc) > 32767) w.temp_centi = 16'h7fff;
      else if ($signed(tc) < -32768) w.temp_centi = 16'h8000;
      else w.temp_centi = tc[15:0];

      p1 = {48'd0, press_cal_a[15:0]};
      p2 = {{48{press_cal_a[31]}}, press_cal_a[31:16]};
      p3 = {{48{press_cal_a[47]}}, press_cal_a[47:32]};
      p4 = {{48{press_cal_a[63]}}, press_cal_a[63:48]};
      p5 = {{48{press_cal_b[15]}}, press_cal_b[15:0]};
      p6 = {{48{press_cal_b[31]}}, press_cal_b[31:16]};
      p7 = {{48{press_cal_b[47]}}, press_cal_b[47:32]};
      p8 = {{48{press_cal_b[63]}}, press_cal_b[63:48]};
      p9 = {{48{press_hum_cal[15]}}, press_hum_cal[15:0]};
      x = {{32{fine[31]}}, fine} - 64'd128000;
      y = x * x * p6;
      q = x * p5;
      y = y + (q << 17);
      y = y + (p4 << 35);
      q = x * x * p3;
      e1 = x * p2;
      x = asr64(q, 8) + (e1 << 12);
      q = (64'h0000_8000_0000_0000 + x) * p1;
      x = asr64(q, 33);
      if (x == 64'd0) begin
         w.fault = 1'b1;
         w.press = 32'd0;
      end else begin
         w.fault = 1'b0;
         pr = 64'd1048576 - {44'd0, rp_in};
         q = ((pr << 31) - y) * 64'd3125;
         pr = div_trunc(q, x);
         q = p9 * asr64(pr, 13) * asr64(pr, 13);
         e1 = asr64(q, 25);
         q = p8 * pr;
         e2 = asr64(q, 19);
         pr = asr64(pr + e1 + e2, 8) + (p7 << 4);
         if (pr[63]) w.press = 32'd0;
         else if (pr > 64'h0000_0000_ffff_ffff) w.press = 32'hffff_ffff;
         else w.press = pr[31:0];
      end

      rh = {16'd0, rh_in};
      h1 = {24'd0, press_hum_cal[23:16]};
      h2 = {{16{press_hum_cal[39]}}, press_hum_cal[39:24]};
      h3 = {24'd0, press_hum_cal[47:40]};
      h4 = {{20{hum_cal[11]}}, hum_cal[11:0]};
      h5 = {{20{hum_cal[23]}}, hum_cal[23:12]};
      h6 = {{24{hum_cal[31]}}, hum_cal[31:24]};
      v = fine - 32'd76800;
      m = h5 * v;
      m = (rh << 14) - (h4 << 20) - m + 32'd16384;
      ha = asr32(m, 15);
      m = v * h6;
      hb = asr32(m, 10);
      m = v * h3;
      hc = asr32(m, 11) + 32'd32768;
      hb = hb * hc;
      m = asr32(hb, 10) + 32'd2097152;
      m = m * h2 + 32'd8192;
      hb = asr32(m, 14);
      v = ha * hb;
      s = asr32(v, 15);
      m = s * s;
      m = asr32(m, 7);
      m = m * h1;
      v = v - asr32(m, 4);
      if (v[31]) v = 32'd0;
      if (v > 32'd419430400) v = 32'd419430400;
      m = v >> 12;
      w.hum = m[16:0];
      return w;
   endfunction

   assign pending = expected_words.size();

   always @(posedge clock) begin
      comp_word_type got, want;
      if (reset) begin
         temp_cal      <= '0;
         press_cal_a   <= '0;
         press_cal_b   <= '0;
         press_hum_cal <= '0;
         hum_cal       <= '0;
         expected_words.delete();
         mismatches    <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_words.push_back(compensate(req_raw_temp, req_raw_press, req_raw_hum));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_temp_centi, rsp_press_q24_8, rsp_hum_q22_10, rsp_press_fault};
            if (expected_words.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected word: temp %0d press %h hum %0d fault %b",
                           $signed(got.temp_centi), got.press, got.hum, got.fault);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_words.pop_front();
               if (got != want) begin
                  if (mismatches < 10)
                     $display({"word mismatch: exp temp %0d press %h hum %0d fault %b,",
                               " got temp %0d press %h hum %0d fault %b"},
                              $signed(want.temp_centi), want.press, want.hum, want.fault,
                              $signed(got.temp_centi), got.press, got.hum, got.fault);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               escu_pkg::CSR_TEMP_CALIB:      temp_cal      <= csr_wdata[47:0];
               escu_pkg::CSR_PRESS_CALIB_A:   press_cal_a   <= csr_wdata;
               escu_pkg::CSR_PRESS_CALIB_B:   press_cal_b   <= csr_wdata;
               escu_pkg::CSR_PRESS_HUM_CALIB: press_hum_cal <= csr_wdata[47:0];
               escu_pkg::CSR_HUM_CALIB:       hum_cal       <= csr_wdata[31:0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- tb/sv/env_sensor_compensation_unit_tb.sv -----
// Testbench top for the sensor compensation unit: clock, reset, calibration phases,
// sample stimulus with random idling, watchdog and verdict.
// Depends on escu_pkg, env_sensor_compensation_unit and its checker.
`timescale 1ns / 1ps
module env_sensor_compensation_unit_tb;

   localparam logic [escu_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_wr_en = 1'b0;
   logic [escu_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                      csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [19:0]                      req_raw_temp = '0;
   logic [19:0]                      req_raw_press = '0;
   logic [15:0]                      req_raw_hum = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [15:0]               rsp_temp_centi;
   logic [31:0]                      rsp_press_q24_8;
   logic [16:0]                      rsp_hum_q22_10;
   logic                             rsp_press_fault;
   int                               mismatches;
   int                               pending;
   bit                               idling = 1'b1;
   int                               stall_left = 0;
   int                               quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   env_sensor_compensation_unit u_top (.*);
   env_sensor_compensation_unit_checker u_checker (.*);

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         rsp_stall = 1'b1;
         stall_left = int'($urandom_range(0, 8));
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      @(negedge clock);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_raw_temp = rt;
      req_raw_press = rp;
      req_raw_hum = rh;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [escu_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      req_valid = 1'b0;
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_calib(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                             logic [47:0] ph, logic [31:0] hc);
      drain();
      write_csr(escu_pkg::CSR_TEMP_CALIB,
                ({$urandom, $urandom} & 64'hffff_0000_0000_0000) | {16'd0, tc});
      write_csr(escu_pkg::CSR_PRESS_CALIB_A, pa);
      write_csr(escu_pkg::CSR_PRESS_CALIB_B, pb);
      write_csr(escu_pkg::CSR_PRESS_HUM_CALIB,
                ({$urandom, $urandom} & 64'hffff_0000_0000_0000) | {16'd0, ph});
      write_csr(escu_pkg::CSR_HUM_CALIB, {$urandom, hc});
   endtask

   task automatic random_samples(int count, bit realistic);
      logic [19:0] rt, rp;
      logic [15:0] rh;
      for (int i = 0; i < count; i++) begin
         if (realistic && $urandom_range(0, 3) != 0) begin
            rt = 20'($urandom_range(400000, 640000));
            rp = 20'($urandom_range(250000, 480000));
            rh = 16'($urandom_range(20000, 40000));
         end else begin
            rt = 20'($urandom);
            rp = 20'($urandom);
            rh = 16'($urandom);
            case ($urandom_range(0, 5))
               0: rt = '1;
               1: rp = '0;
               2: rh = '1;
               default: ;
            endcase
         end
         send_sample(rt, rp, rh);
         if (i == count / 2 && $urandom_range(0, 1) == 0) drain();
      end
   endtask

   localparam logic [47:0] TYP_T  = {16'hfc18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
   localparam logic [63:0] TYP_PB = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
   localparam logic [47:0] TYP_PH = {8'd0, 16'd362, 8'd75, 16'd6000};
   localparam logic [31:0] TYP_H  = {8'd30, 12'd0, 12'd324};

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset calibration: P1 is zero, so every word carries the pressure fault
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'h80000, 20'h55555, 16'haaaa);

      load_calib(TYP_T, TYP_PA, TYP_PB, TYP_PH, TYP_H);
      write_csr(CSR_UNUSED, '1);
      send_sample(20'd519888, 20'd415148, 16'd30000);
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample('0, '1, '0);
      send_sample('1, '0, '1);
      send_sample(20'haaaaa, 20'h55555, 16'h5555);
      send_sample(20'h55555, 20'haaaaa, 16'haaaa);
      send_sample(20'd519888, 20'd1048575, 16'd65535);
      send_sample(20'd519888, 20'd0, 16'd0);

      // divisor forced to zero with otherwise normal words
      load_calib(TYP_T, {TYP_PA[63:16], 16'd0}, TYP_PB, TYP_PH, TYP_H);
      send_sample(20'd519888, 20'd415148, 16'd30000);
      send_sample('1, '1, '1);

      // extremes of every calibration word
      load_calib('1, '1, '1, '1, '1);
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'haaaaa, 20'h55555, 16'h5555);
      load_calib({16'h7fff, 16'h7fff, 16'hffff}, {16'h7fff, 16'h7fff, 16'h7fff, 16'hffff},
                 {4{16'h7fff}}, {8'hff, 16'h7fff, 8'hff, 16'h7fff}, {8'h7f, 12'h7ff, 12'h7ff});
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      load_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                 {4{16'h8000}}, {8'h00, 16'h8000, 8'h00, 16'h8000}, {8'h80, 12'h800, 12'h800});
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'h80000, 20'h80000, 16'h8000);

      load_calib(TYP_T, TYP_PA, TYP_PB, TYP_PH, TYP_H);
      random_samples(300, 1'b1);
      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0)
            load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                       48'({$urandom, $urandom}), $urandom);
         else
            load_calib(TYP_T ^ {16'd0, $urandom & 32'h00ff_00ff},
                       TYP_PA ^ {32'd0, $urandom & 32'h00ff00ff},
                       TYP_PB ^ {32'd0, $urandom & 32'h00ff00ff},
                       TYP_PH ^ {16'd0, $urandom & 32'h00ff},
                       TYP_H ^ ($urandom & 32'h0f0_0ff));
         random_samples(130, bit'(ph % 2));
      end
      load_calib(TYP_T, TYP_PA, TYP_PB, TYP_PH, TYP_H);
      idling = 1'b0;
      random_samples(250, 1'b1);

      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ----- env_sensor_compensation_unit.f -----
+incdir+hw/rtl
hw/rtl/escu_pkg.sv
hw/rtl/escu_div.sv
hw/rtl/env_sensor_compensation_unit.sv
tb/sv/env_sensor_compensation_unit_checker.sv
tb/sv/env_sensor_compensation_unit_tb.sv
